// ===== src/mtmr_pkg.sv =====
package mtmr_pkg;

  localparam int NumTimersDef = 16;
  localparam int IdW          = 16;
  localparam int TicksW       = 20;
  localparam int TagW         = 32;
  localparam int TickMsW      = 10;
  localparam int DurW         = 20;

  localparam logic [TickMsW-1:0] TickMsRst = TickMsW'(10);
  localparam logic [IdW-1:0]     IdFirst   = IdW'(1);

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [IdW-1:0]    id;
    logic [TicksW-1:0] left;
    logic [TicksW-1:0] reload;
    logic [TagW-1:0]   tag;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_SORT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctrl_t;

endpackage

// ===== src/mtmr_in_if.sv =====
interface mtmr_in_if import mtmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [DurW-1:0]    duration_ms;
  logic               periodic;
  logic [IdW-1:0]     cancel_id;
  logic [TagW-1:0]    user_tag;

  modport source (output valid, func, duration_ms, periodic, cancel_id, user_tag,
                  input ready);
  modport sink (input valid, func, duration_ms, periodic, cancel_id, user_tag,
                output ready);
endinterface

// ===== src/mtmr_out_if.sv =====
interface mtmr_out_if import mtmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               ok;
  logic [IdW-1:0]     timer_id;
  logic [TagW-1:0]    tag_out;
  logic               removed;
  logic               last;

  modport source (output valid, kind, ok, timer_id, tag_out, removed, last,
                  input ready);
  modport sink (input valid, kind, ok, timer_id, tag_out, removed, last,
                output ready);
endinterface

// ===== src/multi_timer_one_shot_periodic.sv =====
// Bank of NUM_TIMERS one-shot/periodic timers held in a chain of cells, newest
// first. A start item runs a 21-step bit-serial divider that rounds the
// duration up to ticks, then replies with the new id; a rejected start goes
// straight to the reply. A cancel item makes one rotation of the chain past a
// compare at the head, then NUM_TIMERS odd-even rounds that close gaps, then
// the reply. A tick item makes the same rotation, which decrements each timer
// at the head and emits expiries newest first, one per cycle at most, then
// flushes the last held expiry and runs the same compaction. Every item also
// waits out any output stalls. Inputs are taken only when idle; results leave
// through a registered output stage.
module multi_timer_one_shot_periodic import mtmr_pkg::*; #(
  parameter int NUM_TIMERS = NumTimersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TickMsW-1:0] cfg_wdata_i,
  mtmr_in_if.sink            in_if,
  mtmr_out_if.source         out_if
);

  localparam int CntW = $clog2(NUM_TIMERS + 1);
  localparam int StpW = $clog2(NUM_TIMERS);
  localparam logic [StpW-1:0] StpLast = StpW'(NUM_TIMERS - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(NUM_TIMERS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_REPLY = 6'b000100,
    ST_PASS  = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_SORT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [TagW-1:0] tag;
    logic            removed;
  } expiry_t;

  state_e             state_q, state_d;
  logic [TickMsW-1:0] tick_ms_q;
  logic [TickMsW-1:0] tdiv;
  logic [1:0]         func_q;
  logic               per_q;
  logic [IdW-1:0]     cid_q;
  logic [TagW-1:0]    tag_q;
  logic [DurW:0]      num_q, num_d;
  logic [TickMsW-1:0] rem_q, rem_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic [TickMsW:0]   trial;
  logic [IdW-1:0]     next_id_q, next_id_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [StpW-1:0]    stp_q, stp_d;
  logic               found_q, found_d;
  logic               rep_ok_q, rep_ok_d;
  logic [IdW-1:0]     rep_id_q, rep_id_d;
  logic               ins_q, ins_d;
  logic               hold_vld_q, hold_vld_d;
  expiry_t            hold_q, hold_d;

  logic               out_vld_q;
  logic [1:0]         out_kind_q, out_kind_d;
  logic               out_ok_q, out_ok_d;
  logic [IdW-1:0]     out_id_q, out_id_d;
  logic [TagW-1:0]    out_tag_q, out_tag_d;
  logic               out_rem_q, out_rem_d;
  logic               out_last_q, out_last_d;
  logic               out_ld, out_free;

  cell_ctrl_t             ctrl;
  entry_t                 ins, head, proc_e;
  logic [NUM_TIMERS-1:0]  vld_vec, cnt_mask;
  logic [TicksW-1:0]      left_n;
  logic                   expire, match, advance;
  logic                   in_acc;

  mtmr_chain #(.NumTimers(NUM_TIMERS)) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .ins_i  (ins),
    .head_o (head),
    .vld_o  (vld_vec)
  );

  assign tdiv     = (tick_ms_q == '0) ? TickMsW'(1) : tick_ms_q;
  assign trial    = {rem_q, num_q[DurW]};
  assign out_free = !out_vld_q || out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc   = in_if.valid && in_if.ready;

  assign left_n = (head.left == '0) ? '0 : head.left - TicksW'(1);
  assign expire = (func_q == FUNC_TICK) && head.vld && (left_n == '0);
  assign match  = (func_q == FUNC_CANCEL) && head.vld && (head.id == cid_q) && !found_q;

  always_comb begin
    proc_e = head;
    if (func_q == FUNC_TICK && head.vld) begin
      proc_e.left = left_n;
      if (expire) begin
        if (head.reload != '0) proc_e.left = head.reload;
        else proc_e.vld = 1'b0;
      end
    end
    if (match) proc_e.vld = 1'b0;
  end

  assign advance = !expire || !hold_vld_q || out_free;

  always_comb begin
    state_d    = state_q;
    num_d      = num_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    next_id_d  = next_id_q;
    cnt_d      = cnt_q;
    stp_d      = stp_q;
    found_d    = found_q;
    rep_ok_d   = rep_ok_q;
    rep_id_d   = rep_id_q;
    ins_d      = ins_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    out_ld     = 1'b0;
    out_kind_d = out_kind_q;
    out_ok_d   = out_ok_q;
    out_id_d   = out_id_q;
    out_tag_d  = out_tag_q;
    out_rem_d  = out_rem_q;
    out_last_d = out_last_q;
    ctrl.op    = CELL_HOLD;
    ctrl.phase = stp_q[0];
    ins        = proc_e;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          stp_d   = '0;
          found_d = 1'b0;
          unique case (in_if.func) inside
            FUNC_START: begin
              if (in_if.duration_ms == '0 || cnt_q == CntFull) begin
                rep_ok_d = 1'b0;
                rep_id_d = '0;
                ins_d    = 1'b0;
                state_d  = ST_REPLY;
              end else begin
                num_d   = {1'b0, in_if.duration_ms} + (DurW+1)'(tdiv) - (DurW+1)'(1);
                rem_d   = '0;
                dcnt_d  = '0;
                state_d = ST_DIV;
              end
            end
            FUNC_CANCEL, FUNC_TICK: state_d = ST_PASS;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, tdiv}) begin
          rem_d = TickMsW'(trial - {1'b0, tdiv});
          num_d = {num_q[DurW-1:0], 1'b1};
        end else begin
          rem_d = trial[TickMsW-1:0];
          num_d = {num_q[DurW-1:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'(DurW)) begin
          rep_ok_d = 1'b1;
          rep_id_d = next_id_q;
          ins_d    = 1'b1;
          state_d  = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_kind_d = (func_q == FUNC_START) ? KIND_START : KIND_CANCEL;
          out_ok_d   = rep_ok_q;
          out_id_d   = rep_id_q;
          out_tag_d  = '0;
          out_rem_d  = 1'b0;
          out_last_d = 1'b1;
          if (ins_q) begin
            ctrl.op    = CELL_SHR;
            ins.vld    = 1'b1;
            ins.id     = next_id_q;
            ins.left   = num_q[TicksW-1:0];
            ins.reload = per_q ? num_q[TicksW-1:0] : '0;
            ins.tag    = tag_q;
            next_id_d  = (next_id_q == '1) ? IdFirst : next_id_q + IdW'(1);
            cnt_d      = cnt_q + CntW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (advance) begin
          ctrl.op = CELL_SHL;
          stp_d   = stp_q + StpW'(1);
          if (expire) begin
            if (hold_vld_q) begin
              out_ld     = 1'b1;
              out_kind_d = KIND_EXPIRY;
              out_ok_d   = 1'b1;
              out_id_d   = hold_q.id;
              out_tag_d  = hold_q.tag;
              out_rem_d  = hold_q.removed;
              out_last_d = 1'b0;
            end
            hold_vld_d     = 1'b1;
            hold_d.id      = head.id;
            hold_d.tag     = head.tag;
            hold_d.removed = (head.reload == '0);
            if (head.reload == '0) cnt_d = cnt_q - CntW'(1);
          end
          if (match) begin
            found_d = 1'b1;
            cnt_d   = cnt_q - CntW'(1);
          end
          if (stp_q == StpLast) begin
            stp_d    = '0;
            rep_ok_d = found_q || match;
            rep_id_d = (found_q || match) ? cid_q : '0;
            ins_d    = 1'b0;
            state_d  = (func_q == FUNC_TICK) ? ST_FLUSH : ST_SORT;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = ST_SORT;
        end else if (out_free) begin
          out_ld     = 1'b1;
          out_kind_d = KIND_EXPIRY;
          out_ok_d   = 1'b1;
          out_id_d   = hold_q.id;
          out_tag_d  = hold_q.tag;
          out_rem_d  = hold_q.removed;
          out_last_d = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = ST_SORT;
        end
      end
      ST_SORT: begin
        ctrl.op = CELL_SORT;
        stp_d   = stp_q + StpW'(1);
        if (stp_q == StpLast) begin
          stp_d   = '0;
          state_d = (func_q == FUNC_CANCEL) ? ST_REPLY : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tick_ms_q  <= TickMsRst;
      next_id_q  <= IdFirst;
      cnt_q      <= '0;
      stp_q      <= '0;
      found_q    <= 1'b0;
      ins_q      <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) tick_ms_q <= cfg_wdata_i;
      next_id_q  <= next_id_d;
      cnt_q      <= cnt_d;
      stp_q      <= stp_d;
      found_q    <= found_d;
      ins_q      <= ins_d;
      hold_vld_q <= hold_vld_d;
      dcnt_q     <= dcnt_d;
      if (out_ld) out_vld_q <= 1'b1;
      else if (out_if.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    rep_ok_q <= rep_ok_d;
    rep_id_q <= rep_id_d;
    hold_q   <= hold_d;
    if (in_acc) begin
      func_q <= in_if.func;
      per_q  <= in_if.periodic;
      cid_q  <= in_if.cancel_id;
      tag_q  <= in_if.user_tag;
    end
    if (out_ld) begin
      out_kind_q <= out_kind_d;
      out_ok_q   <= out_ok_d;
      out_id_q   <= out_id_d;
      out_tag_q  <= out_tag_d;
      out_rem_q  <= out_rem_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_if.valid    = out_vld_q;
  assign out_if.kind     = out_kind_q;
  assign out_if.ok       = out_ok_q;
  assign out_if.timer_id = out_id_q;
  assign out_if.tag_out  = out_tag_q;
  assign out_if.removed  = out_rem_q;
  assign out_if.last     = out_last_q;

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      cnt_mask[i] = (CntW'(i) < cnt_q);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("live count above bank size");

  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (vld_vec == cnt_mask)) else $error("bank not compact when idle");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (state_q == ST_PASS || state_q == ST_FLUSH))
    else $error("pending expiry outside tick pass");

endmodule

// ===== src/mtmr_cell.sv =====
module mtmr_cell import mtmr_pkg::*; #(
  parameter bit IsFirst = 1'b0,
  parameter bit IsLast  = 1'b0,
  parameter bit Odd     = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     prv_i,
  input  entry_t     nxt_i,
  output entry_t     ent_o
);

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      CELL_SHL: ent_d = nxt_i;
      CELL_SHR: ent_d = prv_i;
      CELL_SORT: begin
        if (Odd == ctrl_i.phase) begin
          if (!IsLast && !ent_q.vld && nxt_i.vld) ent_d = nxt_i;
        end else begin
          if (!IsFirst && !prv_i.vld && ent_q.vld) ent_d = prv_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.vld <= 1'b0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ===== src/mtmr_chain.sv =====
module mtmr_chain import mtmr_pkg::*; #(
  parameter int NumTimers = NumTimersDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  entry_t               ins_i,
  output entry_t               head_o,
  output logic [NumTimers-1:0] vld_o
);

  entry_t ent [NumTimers];

  for (genvar i = 0; i < NumTimers; i++) begin : g_cell
    entry_t prv, nxt;
    if (i == 0) begin : g_p0
      assign prv = ins_i;
    end else begin : g_pn
      assign prv = ent[i-1];
    end
    if (i == NumTimers - 1) begin : g_n0
      assign nxt = ins_i;
    end else begin : g_nn
      assign nxt = ent[i+1];
    end

    mtmr_cell #(
      .IsFirst (i == 0),
      .IsLast  (i == NumTimers - 1),
      .Odd     (1'(i % 2))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .prv_i  (prv),
      .nxt_i  (nxt),
      .ent_o  (ent[i])
    );

    assign vld_o[i] = ent[i].vld;
  end

  assign head_o = ent[0];

endmodule

// ===== test/multi_timer_one_shot_periodic_tb.sv =====
module multi_timer_one_shot_periodic_tb;
  import mtmr_pkg::*;

  localparam int NT = NumTimersDef;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]      func;
    logic [DurW-1:0] duration_ms;
    logic            periodic;
    logic [IdW-1:0]  cancel_id;
    logic [TagW-1:0] user_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic            ok;
    logic [IdW-1:0]  timer_id;
    logic [TagW-1:0] tag_out;
    logic            removed;
    logic            last;
  } rsp_t;

  typedef struct {
    logic [IdW-1:0]    id;
    logic [TicksW-1:0] left;
    logic [TicksW-1:0] reload;
    logic [TagW-1:0]   tag;
  } timer_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TickMsW-1:0] cfg_wdata_i;

  mtmr_in_if  in_if ();
  mtmr_out_if out_if ();

  multi_timer_one_shot_periodic i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  timer_t bank[$];
  logic [TickMsW-1:0] tick_ms_model;
  logic [IdW-1:0]     next_id_model;
  int     mismatches;
  int     cycles;
  int     send_gap;
  int     recv_gap;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor: updates the timer bank and queues the results of one item
  function automatic void predict_timers(req_t r);
    logic [31:0] t;
    logic [31:0] ticks;
    timer_t nt;
    timer_t kept[$];
    rsp_t rs;
    int k;
    bit found;
    rs = '0;
    rs.last = 1'b1;
    case (r.func)
      FUNC_START: begin
        rs.kind = KIND_START;
        if (r.duration_ms != 0 && bank.size() < NT) begin
          t = (tick_ms_model == 0) ? 32'd1 : 32'(tick_ms_model);
          ticks = (32'(r.duration_ms) + t - 1) / t;
          nt.id = next_id_model;
          nt.left = ticks[TicksW-1:0];
          nt.reload = r.periodic ? ticks[TicksW-1:0] : '0;
          nt.tag = r.user_tag;
          bank.push_front(nt);
          rs.ok = 1'b1;
          rs.timer_id = next_id_model;
          next_id_model = (next_id_model == 16'hFFFF) ? IdFirst : next_id_model + 1'b1;
        end
        expected_rsps.push_back(rs);
      end
      FUNC_CANCEL: begin
        rs.kind = KIND_CANCEL;
        found = 0;
        foreach (bank[i]) begin
          if (!found && bank[i].id == r.cancel_id) begin
            found = 1;
            bank.delete(i);
            rs.ok = 1'b1;
            rs.timer_id = r.cancel_id;
            break;
          end
        end
        expected_rsps.push_back(rs);
      end
      FUNC_TICK: begin
        k = 0;
        foreach (bank[i]) begin
          nt = bank[i];
          nt.left = (nt.left == 0) ? '0 : nt.left - 1'b1;
          if (nt.left == 0) begin
            rs = '0;
            rs.kind = KIND_EXPIRY;
            rs.ok = 1'b1;
            rs.timer_id = nt.id;
            rs.tag_out = nt.tag;
            if (nt.reload != 0) begin
              nt.left = nt.reload;
              kept.push_back(nt);
            end else begin
              rs.removed = 1'b1;
            end
            expected_rsps.push_back(rs);
            k++;
          end else begin
            kept.push_back(nt);
          end
        end
        if (k > 0) expected_rsps[$].last = 1'b1;
        bank = kept;
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_req(logic [1:0] f, logic [DurW-1:0] d, logic p,
                                    logic [IdW-1:0] c, logic [TagW-1:0] g);
    req_t r;
    r.func = f;
    r.duration_ms = d;
    r.periodic = p;
    r.cancel_id = c;
    r.user_tag = g;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int sel;
    r = make_req(FUNC_TICK, DurW'($urandom), 1'($urandom), IdW'($urandom), $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      r.func = FUNC_START;
      case ($urandom_range(0, 5))
        0: r.duration_ms = '0;
        1: r.duration_ms = DurW'($urandom);
        default: r.duration_ms = DurW'($urandom_range(1, 60));
      endcase
    end else if (sel < 50) begin
      r.func = FUNC_CANCEL;
      if (bank.size() > 0 && $urandom_range(0, 2) != 0)
        r.cancel_id = bank[$urandom_range(0, bank.size() - 1)].id;
    end else if (sel < 97) begin
      r.func = FUNC_TICK;
    end else begin
      r.func = 2'd3;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.func        <= '0;
      in_if.duration_ms <= '0;
      in_if.periodic    <= 1'b0;
      in_if.cancel_id   <= '0;
      in_if.user_tag    <= '0;
      send_gap <= 0;
    end else if (in_if.valid && !in_if.ready) begin
    end else if (send_gap > 0) begin
      in_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req_t r;
      r = pending_reqs.pop_front();
      predict_timers(r);
      in_if.valid       <= 1'b1;
      in_if.func        <= r.func;
      in_if.duration_ms <= r.duration_ms;
      in_if.periodic    <= r.periodic;
      in_if.cancel_id   <= r.cancel_id;
      in_if.user_tag    <= r.user_tag;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        rsp_t got;
        rsp_t exp;
        got = {out_if.kind, out_if.ok, out_if.timer_id, out_if.tag_out,
               out_if.removed, out_if.last};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp = expected_rsps.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", exp, got);
          end
        end
      end
      if (recv_gap > 0) begin
        out_if.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_if.ready <= 1'b1;
        if (out_if.valid && out_if.ready)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    while (in_if.valid || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (4 * NT + 40) @(posedge clk_i);
  endtask

  task automatic write_tick_ms(logic [TickMsW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    tick_ms_model = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [TickMsW-1:0] settings[5];
    settings = '{TickMsW'(1), TickMsW'(1000), TickMsW'(0), TickMsW'(7), TickMsW'(1023)};
    tick_ms_model = TickMsRst;
    next_id_model = IdFirst;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4 * NT + 40) @(posedge clk_i);

    // directed: default tick_ms, rounding, zero duration, full bank, cancel cases
    pending_reqs.push_back(make_req(FUNC_START, '0, 1'b0, '0, '1));
    pending_reqs.push_back(make_req(FUNC_START, 20'd1, 1'b0, '0, 32'hFFFFFFFF));
    pending_reqs.push_back(make_req(FUNC_START, 20'd11, 1'b1, '0, 32'h0));
    pending_reqs.push_back(make_req(FUNC_START, '1, 1'b1, '0, 32'hA5A5A5A5));
    pending_reqs.push_back(make_req(FUNC_CANCEL, '0, 1'b0, 16'd0, '0));
    pending_reqs.push_back(make_req(FUNC_CANCEL, '0, 1'b0, 16'hFFFF, '0));
    pending_reqs.push_back(make_req(FUNC_TICK, '0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_TICK, '0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_TICK, '0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(2'd3, '1, 1'b1, '1, '1));
    pending_reqs.push_back(make_req(FUNC_CANCEL, '0, 1'b0, 16'd4, '0));
    for (int i = 0; i < 14; i++)
      pending_reqs.push_back(make_req(FUNC_START, DurW'(10 * (i + 1)), 1'(i), '0, $urandom));
    drain();
    pending_reqs.push_back(make_req(FUNC_START, 20'd5, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_CANCEL, '0, 1'b0, 16'd3, '0));
    drain();

    // random phases, each with its own tick_ms
    foreach (settings[s]) begin
      write_tick_ms(settings[s]);
      for (int i = 0; i < 15; i++) begin
        wait (pending_reqs.size() == 0);
        pending_reqs.push_back(rand_req());
        @(posedge clk_i);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
